// ----- src/kct_pkg.sv -----
// kct_pkg: types, codes and sizes shared by the keyed count table
// depends on nothing; used by every file of the block
package kct_pkg;

   localparam int SLOTS      = 16;
   localparam int KEY_BITS   = 8;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int ENTRY_BITS = $clog2(SLOTS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // action codes
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_TAKE   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_APPEND = 2'd3;

   // status codes
   localparam logic [3:0] ST_INC  = 4'd0;
   localparam logic [3:0] ST_INS  = 4'd1;
   localparam logic [3:0] ST_DEC  = 4'd2;
   localparam logic [3:0] ST_REM  = 4'd3;
   localparam logic [3:0] ST_MISS = 4'd4;
   localparam logic [3:0] ST_FULL = 4'd5;
   localparam logic [3:0] ST_CLR  = 4'd6;
   localparam logic [3:0] ST_APP  = 4'd7;
   localparam logic [3:0] ST_SAT  = 4'd8;

   typedef struct packed {
      logic [1:0]            action;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] quantity;
   } req_type;

   typedef struct packed {
      logic [3:0]            status;
      logic [SLOT_BITS-1:0]  slot;
      logic [COUNT_BITS-1:0] count_after;
      logic [ENTRY_BITS-1:0] entries_now;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic look;
      logic exec;
   } cmd_type;

endpackage

// ----- src/kct_ctrl.sv -----
// kct_ctrl: sequencer for capture, lookup and update of one beat
// depends on kct_pkg
module kct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kct_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new beat
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_EXEC) && out_free);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load = req_valid && req_ready;
   assign cmd.look = (state_ff == S_LOOK);
   assign cmd.exec = (state_ff == S_EXEC) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = cmd.load ? S_LOOK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/kct_datapath.sv -----
// kct_datapath: entry registers, key match, update, compaction and output register
// depends on kct_pkg; driven by kct_ctrl commands
module kct_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  kct_pkg::cmd_type                 cmd,
   input  kct_pkg::req_type                 req_data,
   input  logic                             csr_valid,
   input  logic [kct_pkg::COUNT_BITS-1:0]   csr_data,
   output kct_pkg::rsp_type                 rsp_data
);

   localparam int SB = kct_pkg::SLOT_BITS;
   localparam int EB = kct_pkg::ENTRY_BITS;
   localparam int KB = kct_pkg::KEY_BITS;
   localparam int CB = kct_pkg::COUNT_BITS;
   localparam int NS = kct_pkg::SLOTS;

   // captured request
   logic [1:0]    act_ff;
   logic [KB-1:0] key_ff;
   logic [CB-1:0] qty_ff;

   // table and fill count
   logic [KB-1:0] keys_ff   [NS];
   logic [KB-1:0] keys_in   [NS];
   logic [CB-1:0] counts_ff [NS];
   logic [CB-1:0] counts_in [NS];
   logic [EB-1:0] occ_ff, occ_in;

   // lookup results
   logic          hit_ff, hit_in;
   logic [SB-1:0] hit_idx_ff, hit_idx_in;
   logic [CB-1:0] hit_cnt_ff;

   logic [CB-1:0]      lim_ff;
   kct_pkg::rsp_type   rsp_ff, rsp_in;

   logic          full;
   logic [SB-1:0] tail;
   logic [CB-1:0] qty_clamp;

   assign full     = (occ_ff == EB'(NS));
   assign tail     = occ_ff[SB-1:0];
   assign rsp_data = rsp_ff;

   // limit register, never below one
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= kct_pkg::COUNT_MAX;
      end else if (csr_valid) begin
         lim_ff <= (csr_data == '0) ? CB'(1) : csr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_data.action;
         key_ff <= req_data.key;
         qty_ff <= req_data.quantity;
      end
   end

   // parallel key match, highest slot wins
   always_comb begin
      hit_in     = 1'b0;
      hit_idx_in = '0;
      for (int i = 0; i < NS; i++) begin
         if ((EB'(i) < occ_ff) && (keys_ff[i] == key_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = SB'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
         hit_cnt_ff <= counts_ff[hit_idx_in];
      end
   end

   // append quantity held within one and the limit
   always_comb begin
      qty_clamp = qty_ff;
      if (qty_clamp == '0)   qty_clamp = CB'(1);
      if (qty_clamp > lim_ff) qty_clamp = lim_ff;
   end

   // update of table and response
   always_comb begin
      keys_in   = keys_ff;
      counts_in = counts_ff;
      occ_in    = occ_ff;
      rsp_in    = '0;
      case (act_ff)
         kct_pkg::ACT_ADD: begin
            if (hit_ff) begin
               rsp_in.slot = hit_idx_ff;
               if (hit_cnt_ff >= lim_ff) begin
                  rsp_in.status      = kct_pkg::ST_SAT;
                  rsp_in.count_after = hit_cnt_ff;
               end else begin
                  counts_in[hit_idx_ff] = hit_cnt_ff + CB'(1);
                  rsp_in.status         = kct_pkg::ST_INC;
                  rsp_in.count_after    = hit_cnt_ff + CB'(1);
               end
            end else if (!full) begin
               keys_in[tail]      = key_ff;
               counts_in[tail]    = CB'(1);
               occ_in             = occ_ff + EB'(1);
               rsp_in.status      = kct_pkg::ST_INS;
               rsp_in.slot        = tail;
               rsp_in.count_after = CB'(1);
            end else begin
               rsp_in.status = kct_pkg::ST_FULL;
            end
         end
         kct_pkg::ACT_TAKE: begin
            if (!hit_ff) begin
               rsp_in.status = kct_pkg::ST_MISS;
            end else if (hit_cnt_ff <= CB'(1)) begin
               // close the gap: later entries move down one slot
               for (int i = 0; i < NS - 1; i++) begin
                  if (SB'(i) >= hit_idx_ff) begin
                     keys_in[i]   = keys_ff[i+1];
                     counts_in[i] = counts_ff[i+1];
                  end
               end
               occ_in        = occ_ff - EB'(1);
               rsp_in.status = kct_pkg::ST_REM;
               rsp_in.slot   = hit_idx_ff;
            end else begin
               counts_in[hit_idx_ff] = hit_cnt_ff - CB'(1);
               rsp_in.status         = kct_pkg::ST_DEC;
               rsp_in.slot           = hit_idx_ff;
               rsp_in.count_after    = hit_cnt_ff - CB'(1);
            end
         end
         kct_pkg::ACT_CLEAR: begin
            occ_in        = '0;
            rsp_in.status = kct_pkg::ST_CLR;
         end
         default: begin
            if (full) begin
               rsp_in.status = kct_pkg::ST_FULL;
            end else begin
               keys_in[tail]      = key_ff;
               counts_in[tail]    = qty_clamp;
               occ_in             = occ_ff + EB'(1);
               rsp_in.status      = kct_pkg::ST_APP;
               rsp_in.slot        = tail;
               rsp_in.count_after = qty_clamp;
            end
         end
      endcase
      rsp_in.entries_now = occ_in;
   end

   // table entries, undefined until written
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         keys_ff   <= keys_in;
         counts_ff <= counts_in;
         rsp_ff    <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.exec) begin
         occ_ff <= occ_in;
      end
   end

endmodule

// ----- src/keyed_count_table.sv -----
// keyed_count_table: top level joining controller and datapath
// depends on kct_pkg, kct_ctrl and kct_datapath
//
// A table of up to 16 (key, count) entries kept densely in slots from 0.
// req channel: one beat carries action, key and quantity. Add one bumps
// the count of the highest matching slot (saturating at the limit) or
// appends the key; take one drops the count and removes the entry at one,
// closing the gap; clear empties the table; append stores key and count.
// rsp channel: one beat per request with status, slot, count after and
// the number of occupied slots.
// csr channel: writes the count limit; always ready. The user must
// write it only while idle; the block itself does not enforce this.
// A request is captured, its key match registered, then its update goes
// into the output register once free. A new request is taken during
// the last one's update, not its lookup; both stages share the table bank.
// A stalled receiver holds the response in the output register; a request
// may still be captured and matched, and its update waits for the slot.
// Reset empties the table and sets the limit to 65535; no clearing pass.
module keyed_count_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kct_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kct_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kct_pkg::COUNT_BITS-1:0]  csr_data
);

   kct_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   kct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   kct_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/kct_checker.sv -----
// kct_checker: port level checks of the keyed count table
// depends on kct_pkg; bound to keyed_count_table
module kct_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kct_pkg::rsp_type rsp_data
);

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request at a time through the lookup
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during lookup");

   // each request yields a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##3 rsp_valid)
      else $error("response missing after request");

   // no entry touched means slot and count are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == kct_pkg::ST_MISS ||
                    rsp_data.status == kct_pkg::ST_FULL ||
                    rsp_data.status == kct_pkg::ST_CLR)
      |-> rsp_data.slot == '0 && rsp_data.count_after == '0)
      else $error("untouched response carries slot or count");

   // fill count within the table size, status within the known codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entries_now <= kct_pkg::ENTRY_BITS'(kct_pkg::SLOTS)
                 && rsp_data.status <= kct_pkg::ST_SAT)
      else $error("response code or fill count out of range");

endmodule

bind keyed_count_table kct_checker u_kct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- verif/kct_table_checker.sv -----
// kct_table_checker: passive watcher of the keyed count table channels
// keeps its own copy of the table and the count limit, checks each rsp beat in order
// depends on kct_pkg
module kct_table_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  kct_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  kct_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [kct_pkg::COUNT_BITS-1:0] csr_data,
   output int                             errors,
   output int                             in_flight
);
   import kct_pkg::*;

   // shadow table, packed from slot 0
   logic [KEY_BITS-1:0]   key_tab [SLOTS];
   logic [COUNT_BITS-1:0] cnt_tab [SLOTS];
   int                    used = 0;
   logic [COUNT_BITS-1:0] limit_reg = COUNT_MAX;
   rsp_type               expected_rsp [$];
   int                    err_count = 0;

   assign errors = err_count;

   task automatic report(input string what);
      $display("kct check %0t: %s", $time, what);
      err_count++;
   endtask

   // one request applied to the shadow table, giving the response it should cause
   function automatic rsp_type table_step(input req_type beat);
      rsp_type               res;
      logic [COUNT_BITS-1:0] lim;
      logic [COUNT_BITS-1:0] start;
      int                    hit;
      int                    i;
      lim = limit_reg;
      if (lim == '0) lim = COUNT_BITS'(1);
      // highest matching slot wins
      hit = -1;
      for (i = 0; i < used; i++) begin
         if (key_tab[i] == beat.key) hit = i;
      end
      res = '0;
      case (beat.action)
         ACT_ADD: begin
            if (hit >= 0) begin
               // an entry at or above the limit stays as it is
               if (cnt_tab[hit] >= lim) begin
                  res.status = ST_SAT;
               end else begin
                  cnt_tab[hit] = cnt_tab[hit] + 1'b1;
                  res.status = ST_INC;
               end
               res.slot        = hit[SLOT_BITS-1:0];
               res.count_after = cnt_tab[hit];
            end else if (used < SLOTS) begin
               key_tab[used]   = beat.key;
               cnt_tab[used]   = COUNT_BITS'(1);
               res.status      = ST_INS;
               res.slot        = used[SLOT_BITS-1:0];
               res.count_after = COUNT_BITS'(1);
               used++;
            end else begin
               res.status = ST_FULL;
            end
         end
         ACT_TAKE: begin
            if (hit < 0) begin
               res.status = ST_MISS;
            end else if (cnt_tab[hit] <= 1) begin
               // remove and close the gap
               for (i = hit; i + 1 < used; i++) begin
                  key_tab[i] = key_tab[i + 1];
                  cnt_tab[i] = cnt_tab[i + 1];
               end
               used--;
               res.status = ST_REM;
               res.slot   = hit[SLOT_BITS-1:0];
            end else begin
               cnt_tab[hit]    = cnt_tab[hit] - 1'b1;
               res.status      = ST_DEC;
               res.slot        = hit[SLOT_BITS-1:0];
               res.count_after = cnt_tab[hit];
            end
         end
         ACT_CLEAR: begin
            used       = 0;
            res.status = ST_CLR;
         end
         default: begin
            if (used >= SLOTS) begin
               res.status = ST_FULL;
            end else begin
               // starting count held between 1 and the limit
               start = beat.quantity;
               if (start == '0) start = COUNT_BITS'(1);
               if (start > lim) start = lim;
               key_tab[used]   = beat.key;
               cnt_tab[used]   = start;
               res.status      = ST_APP;
               res.slot        = used[SLOT_BITS-1:0];
               res.count_after = start;
               used++;
            end
         end
      endcase
      res.entries_now = used[ENTRY_BITS-1:0];
      return res;
   endfunction

   // per edge: rsp beat checked first, then csr and req beats update the shadow
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         used      = 0;
         limit_reg = COUNT_MAX;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report($sformatf("rsp beat %h with nothing outstanding", rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report($sformatf("status %0d, wanted %0d", rsp_data.status, want.status));
               if (rsp_data.slot !== want.slot)
                  report($sformatf("slot %0d, wanted %0d", rsp_data.slot, want.slot));
               if (rsp_data.count_after !== want.count_after)
                  report($sformatf("count_after %0d, wanted %0d",
                                   rsp_data.count_after, want.count_after));
               if (rsp_data.entries_now !== want.entries_now)
                  report($sformatf("entries_now %0d, wanted %0d",
                                   rsp_data.entries_now, want.entries_now));
            end
         end
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_valid && req_ready) expected_rsp.push_back(table_step(req_data));
      end
      in_flight <= expected_rsp.size();
   end

endmodule

// ----- verif/tb_keyed_count_table.sv -----
// tb_keyed_count_table: stimulus and verdict for the keyed count table
// depends on kct_pkg, keyed_count_table and kct_table_checker
module tb_keyed_count_table;
   import kct_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 66;
   localparam int HOLD_CYCLES   = 80;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data  = '0;
   int                    fail_count;
   int                    in_flight;
   int                    cycles    = 0;
   bit                    no_idle   = 1'b0;
   int                    hold_asks = 0;

   keyed_count_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   kct_table_checker table_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .errors    (fail_count),
      .in_flight (in_flight)
   );

   // clock, period 10
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("keyed_count_table: mismatch");
         $finish;
      end
   end

   // one req beat after a random gap, held until accepted
   task automatic send_req(input logic [1:0] act, input logic [KEY_BITS-1:0] k,
                           input logic [COUNT_BITS-1:0] q);
      int      gap;
      req_type beat;
      gap         = no_idle ? 0 : $urandom_range(0, 11);
      beat.action   = act;
      beat.key      = k;
      beat.quantity = q;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // limit written only once every response is back
   task automatic set_limit(input logic [COUNT_BITS-1:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random request, keys mostly from a narrow pool so lookups hit
   task automatic random_request(input int key_span);
      logic [31:0]           rnd;
      logic [1:0]            act;
      logic [KEY_BITS-1:0]   k;
      logic [COUNT_BITS-1:0] q;
      int                    pick;
      pick = $urandom_range(0, 99);
      if (pick < 42) act = ACT_ADD;
      else if (pick < 78) act = ACT_TAKE;
      else if (pick < 96) act = ACT_APPEND;
      else act = ACT_CLEAR;
      rnd = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, key_span);
      k   = rnd[KEY_BITS-1:0];
      rnd = $urandom;
      case ($urandom_range(0, 5))
         0: q = '0;
         1: q = COUNT_BITS'(1);
         2: begin
            q      = '0;
            q[3:0] = rnd[3:0];
         end
         3: q = '1;
         default: q = rnd[COUNT_BITS-1:0];
      endcase
      send_req(act, k, q);
   endtask

   // receiver: random stall per beat, one long hold-off on request
   initial begin : rsp_side
      int stall;
      int served;
      served = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_asks != served) begin
            stall = HOLD_CYCLES;
            served++;
         end else if (no_idle) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int                    i;
      int                    ph;
      int                    span;
      logic [31:0]           rnd;
      logic [COUNT_BITS-1:0] lim;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // basic paths on a near-empty table
      send_req(ACT_TAKE,   8'h00, 16'h0000);
      send_req(ACT_ADD,    8'h00, 16'hFFFF);
      send_req(ACT_ADD,    8'hFF, 16'h0000);
      send_req(ACT_ADD,    8'h00, 16'h0000);
      send_req(ACT_TAKE,   8'hFF, 16'h0000);
      // append with zero quantity, then at the top count and saturate
      send_req(ACT_APPEND, 8'hA5, 16'h0000);
      send_req(ACT_APPEND, 8'h5A, 16'hFFFF);
      send_req(ACT_ADD,    8'h5A, 16'h0000);
      // duplicate key: the later slot is the one used
      send_req(ACT_APPEND, 8'h00, 16'h0007);
      send_req(ACT_TAKE,   8'h00, 16'h0000);
      // removal from the middle shifts later entries down
      send_req(ACT_TAKE,   8'hA5, 16'h0000);
      // appends and takes of key 00; add and append fill the table
      for (i = 0; i < SLOTS - 3; i++) begin
         rnd = i * 37 + 1;
         send_req(ACT_APPEND, rnd[KEY_BITS-1:0], 16'h0000);
         rnd = $urandom_range(0, 65535);
         lim = rnd[COUNT_BITS-1:0];
         send_req(ACT_TAKE, 8'h00, lim);
      end
      send_req(ACT_ADD,    8'h3C, 16'h0000);
      send_req(ACT_APPEND, 8'hC3, 16'h1234);
      send_req(ACT_CLEAR,  8'hFF, 16'hFFFF);

      // limit of one: append clamps, add saturates at once
      set_limit(16'd1);
      send_req(ACT_APPEND, 8'h11, 16'd500);
      send_req(ACT_ADD,    8'h11, 16'h0000);
      // count left above a lowered limit
      set_limit(16'hFFFF);
      send_req(ACT_APPEND, 8'h22, 16'd1000);
      set_limit(16'd3);
      send_req(ACT_ADD,    8'h22, 16'h0000);
      send_req(ACT_TAKE,   8'h22, 16'h0000);
      send_req(ACT_CLEAR,  8'h00, 16'h0000);

      // random phases, each under its own limit
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: lim = 16'd3;
            1: lim = 16'hFFFF;
            2: begin
               rnd = $urandom_range(2, 12);
               lim = rnd[COUNT_BITS-1:0];
            end
            3: lim = 16'd1;
            4: begin
               rnd = $urandom_range(1, 65535);
               lim = rnd[COUNT_BITS-1:0];
            end
            5: lim = 16'hFFFF;
            6: lim = 16'd2;
            default: begin
               rnd = $urandom_range(1, 40);
               lim = rnd[COUNT_BITS-1:0];
            end
         endcase
         span = (ph % 3 == 0) ? 7 : ((ph % 3 == 1) ? 20 : 40);
         set_limit(lim);
         // back-pressure: receiver holds off while requests keep coming
         if (ph == 2) begin
            no_idle = 1'b1;
            hold_asks++;
         end
         if (ph == 5) no_idle = 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 2 && i == 24) no_idle = 1'b0;
            random_request(span);
         end
         no_idle = 1'b0;
      end

      // drain
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("keyed_count_table: match");
      end else begin
         $display("keyed_count_table: mismatch");
      end
      $finish;
   end

endmodule
